/* rtl/core/tdpt_pkg.sv */
// shared types and constants for the trial-division prime test
package tdpt_pkg;

  localparam int VALUE_W = 32;
  localparam int LIMIT_W = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000000);

  // compare width for candidate against limit
  localparam int CMP_W = (VALUE_W > LIMIT_W) ? VALUE_W : LIMIT_W;
  // divisor never passes sqrt(2^VALUE_W) + 2
  localparam int J_W   = (VALUE_W + 1) / 2 + 2;
  // square of the divisor, one bit of headroom over the candidate
  localparam int SQ_W  = VALUE_W + 1;
  localparam int CNT_W = $clog2(VALUE_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BOUND,
    ST_DIV,
    ST_EVAL
  } state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic next_j;
    logic finish;
    logic prime;
  } cmd_t;

  typedef struct packed {
    logic above;
    logic lt2;
    logic eq2;
    logic even;
    logic sq_gt;
    logic last_bit;
    logic rem_zero;
  } sts_t;

endpackage

/* rtl/core/tdpt_ctrl.sv */
// controller state machine for the trial-division prime test
module tdpt_ctrl
  import tdpt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy,
  output logic cfg_ready_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.above || sts_i.lt2 || sts_i.eq2 || sts_i.even) state_d = ST_IDLE;
        else state_d = ST_BOUND;
      end
      ST_BOUND: begin
        if (sts_i.sq_gt) state_d = ST_IDLE;
        else state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.last_bit) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts_i.rem_zero) state_d = ST_IDLE;
        else state_d = ST_BOUND;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = start;
      end
      ST_CHECK: begin
        if (sts_i.above || sts_i.lt2 || sts_i.even) begin
          cmd_o.finish = 1'b1;
        end else if (sts_i.eq2) begin
          cmd_o.finish = 1'b1;
          cmd_o.prime  = 1'b1;
        end
        // odd with eq2 false: trials follow
        if (sts_i.eq2 && !sts_i.above) begin
          cmd_o.finish = 1'b1;
          cmd_o.prime  = 1'b1;
        end
      end
      ST_BOUND: begin
        if (sts_i.sq_gt) begin
          cmd_o.finish = 1'b1;
          cmd_o.prime  = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_EVAL: begin
        if (sts_i.rem_zero) cmd_o.finish = 1'b1;
        else cmd_o.next_j = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);

endmodule

/* rtl/core/tdpt_dp.sv */
// datapath: limit register, candidate, divisor stepping and serial remainder unit
module tdpt_dp
  import tdpt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [VALUE_W-1:0] candidate_i,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_data_i,
  output logic               done_o,
  output logic [VALUE_W-1:0] tested_value_o,
  output logic               is_prime_o,
  output logic               out_of_range_o
);

  logic [LIMIT_W-1:0] limit_q;
  logic [VALUE_W-1:0] cand_q;
  logic [J_W-1:0]     j_q, j_d;
  logic [SQ_W-1:0]    sq_q, sq_d;
  logic [VALUE_W-1:0] shr_q, shr_d;
  logic [J_W:0]       rem_q, rem_d, rem_sh;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, prime_q, oor_q;
  logic               above;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      done_q <= cmd_i.finish;
    end
  end

  assign above = CMP_W'(cand_q) > CMP_W'(limit_q);

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_q[J_W-1:0], shr_q[VALUE_W-1]};
    j_d    = j_q;
    sq_d   = sq_q;
    shr_d  = shr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (cmd_i.load) begin
      j_d  = J_W'(3);
      sq_d = SQ_W'(9);
    end
    if (cmd_i.div_start) begin
      shr_d = cand_q;
      rem_d = '0;
      cnt_d = CNT_W'(VALUE_W);
    end
    if (cmd_i.div_step) begin
      rem_d = (rem_sh >= {1'b0, j_q}) ? (rem_sh - {1'b0, j_q}) : rem_sh;
      shr_d = shr_q << 1;
      cnt_d = cnt_q - CNT_W'(1);
    end
    if (cmd_i.next_j) begin
      // (j+2)^2 = j^2 + 4j + 4
      j_d  = j_q + J_W'(2);
      sq_d = sq_q + (SQ_W'(j_q) << 2) + SQ_W'(4);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) cand_q <= candidate_i;
    j_q   <= j_d;
    sq_q  <= sq_d;
    shr_q <= shr_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    if (cmd_i.finish) begin
      prime_q <= cmd_i.prime;
      oor_q   <= above;
    end
  end

  assign sts_o.above    = above;
  assign sts_o.lt2      = cand_q < VALUE_W'(2);
  assign sts_o.eq2      = cand_q == VALUE_W'(2);
  assign sts_o.even     = ~cand_q[0];
  assign sts_o.sq_gt    = sq_q > SQ_W'(cand_q);
  assign sts_o.last_bit = cnt_q == CNT_W'(1);
  assign sts_o.rem_zero = rem_q == '0;

  assign done_o         = done_q;
  assign tested_value_o = cand_q;
  assign is_prime_o     = prime_q;
  assign out_of_range_o = oor_q;

endmodule

/* rtl/core/trial_division_prime_test.sv */
// top level: trial-division prime test, controller plus datapath
// out-of-range, below two, two and even candidates finish in ST_CHECK; odd ones go on
// to ST_BOUND and run one trial per odd divisor until a divisor divides or the bound
// ends the loop; a trial is ST_BOUND, a VALUE_W-step serial remainder in ST_DIV, ST_EVAL
// throughput: one candidate at a time, start taken again in the done_o cycle; no stall
// reset: asynchronous, active low; upper limit returns to 1000000, block idles
module trial_division_prime_test
  import tdpt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // command beat
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] candidate_i,
  // configuration beat: upper limit
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_data_i,
  // result beat, one cycle strobe, cannot be stalled
  output logic               done_o,
  output logic [VALUE_W-1:0] tested_value_o,
  output logic               is_prime_o,
  output logic               out_of_range_o
);

  cmd_t cmd;
  sts_t sts;

  tdpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy        (busy),
    .cfg_ready_o (cfg_ready_o)
  );

  // limit is only written while the controller idles
  tdpt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .candidate_i    (candidate_i),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .tested_value_o (tested_value_o),
    .is_prime_o     (is_prime_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

/* tb/trial_division_prime_test_test.sv */
// testbench for the trial-division prime test: random and edge candidates under several limits
`timescale 1ns / 100ps

module trial_division_prime_test_test;
  import tdpt_pkg::*;

  // one verdict per candidate, in the order the block returns them
  typedef struct packed {
    logic [VALUE_W-1:0] tested_value;
    logic               is_prime;
    logic               out_of_range;
  } verdict_t;

  localparam int N_PHASES = 7;
  // no beat for this long means the block is stuck; the slowest candidate used here
  // is an in-range prime just under 2^20
  localparam int unsigned WATCHDOG_CYCLES = 200000;
  // wait after the drain, long enough for two trial divisors
  localparam int TAIL_CYCLES = 2 * (VALUE_W + 2);
  // in-range candidates above this are kept quick so the run stays short
  localparam logic [VALUE_W-1:0] FAST_FLOOR = VALUE_W'(1) << 20;

  // limit per phase: reset value first, then the low extremes, the top, a random one, reset again
  localparam int RANDOM_PER_PHASE [N_PHASES] = '{150, 40, 40, 40, 150, 100, 80};

  // edge candidates and the phase each belongs to
  localparam int N_EDGE = 24;
  localparam logic [VALUE_W-1:0] EDGE_VALUES [N_EDGE] = '{
    // limit at reset: zero, one, two, small primes, odd prime squares where the
    // loop bound is hit exactly, largest 16-bit prime, largest prime below the limit,
    // the limit itself, one past it, top bit alone, all ones
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd9, 32'd25, 32'd97, 32'd121, 32'd63001,
    32'd65521, 32'd999983, 32'd1000000, 32'd1000001, 32'h8000_0000, 32'hFFFF_FFFF,
    // limit zero: only zero is in range
    32'd0, 32'd1,
    // limit one
    32'd1, 32'd2,
    // limit two: two is the only prime in range
    32'd2, 32'd3,
    // limit at the top: nothing is out of range
    32'hFFFF_FFFF, 32'hFFFF_FFFE
  };
  localparam int EDGE_PHASE [N_EDGE] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    1, 1,
    2, 2,
    3, 3,
    4, 4
  };

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic [VALUE_W-1:0] candidate_i    = '0;
  logic               cfg_valid_i    = 1'b0;
  logic               cfg_ready_o;
  logic [LIMIT_W-1:0] cfg_data_i     = '0;
  logic               done_o;
  logic [VALUE_W-1:0] tested_value_o;
  logic               is_prime_o;
  logic               out_of_range_o;

  trial_division_prime_test uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .candidate_i    (candidate_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .tested_value_o (tested_value_o),
    .is_prime_o     (is_prime_o),
    .out_of_range_o (out_of_range_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // testbench copy of the limit register, follows every write beat
  logic [LIMIT_W-1:0] limit_model = LIMIT_RESET;
  logic [LIMIT_W-1:0] phase_limit [N_PHASES] = '{
    LIMIT_RESET, LIMIT_W'(0), LIMIT_W'(1), LIMIT_W'(2), {LIMIT_W{1'b1}}, LIMIT_W'(50000),
    LIMIT_RESET
  };

  logic [VALUE_W-1:0] cand_q [$];     // candidates not yet offered to the block
  verdict_t           verdict_q [$];  // verdicts predicted for accepted candidates

  logic        cmd_beat     = 1'b0;  // candidate taken at the last rising edge
  int          outstanding  = 0;     // accepted candidates without a result yet
  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;
  int unsigned quiet_cycles = 0;
  int          mismatches   = 0;
  int          n_tested     = 0;
  int          n_prime      = 0;
  int          n_oor        = 0;

  // expected verdict for one candidate under the current limit
  function automatic verdict_t predict_verdict(logic [VALUE_W-1:0] cand);
    verdict_t           v;
    logic [VALUE_W-1:0] j;
    logic               prime;
    v.tested_value = cand;
    v.out_of_range = 64'(cand) > 64'(limit_model);
    prime = 1'b0;
    if (!v.out_of_range) begin
      if (cand == VALUE_W'(2)) begin
        prime = 1'b1;
      end else if (cand > VALUE_W'(2) && cand[0]) begin
        // odd divisors only, bound j*j <= cand written without the product
        prime = 1'b1;
        j = VALUE_W'(3);
        while (prime && j <= cand / j) begin
          if (cand % j == '0) prime = 1'b0;
          j = j + VALUE_W'(2);
        end
      end
    end
    v.is_prime = prime;
    return v;
  endfunction

  // random candidate: mostly small values, some near the limit, some full width
  function automatic logic [VALUE_W-1:0] draw_candidate();
    int unsigned        pick;
    logic [VALUE_W-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 40) v = VALUE_W'($urandom_range(0, 4095));
    else if (pick < 65) v = VALUE_W'($urandom_range(0, 65535));
    else if (pick < 75) v = limit_model + VALUE_W'($urandom_range(0, 8)) - VALUE_W'(4);
    else if (pick < 90) v = VALUE_W'($urandom);
    else if (pick < 95) v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
    else v = ~(VALUE_W'(1) << $urandom_range(0, VALUE_W - 1));
    // a large odd candidate in range could be a prime with 32k trials; pulling it
    // down to a multiple of three (or an even value) ends the test on the first trial
    if (v > FAST_FLOOR && 64'(v) <= 64'(limit_model) && v[0]) v = v - v % VALUE_W'(3);
    return v;
  endfunction

  // sender: bursts of candidates with random gaps, a candidate stays on the port
  // until it is taken, and a back-to-back one is offered while the block is busy
  always @(negedge clk_i) begin
    if (rst_ni && !(start && !cmd_beat)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (cand_q.size() != 0) begin
        start       <= 1'b1;
        candidate_i <= cand_q.pop_front();
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          // now and then a long stretch with no gaps at all
          burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predicts on each command beat, checks each result beat, runs the watchdog
  always @(posedge clk_i) begin : result_check
    verdict_t want;
    verdict_t got;
    cmd_beat <= rst_ni && start && !busy;
    if (rst_ni) begin
      outstanding <= outstanding + int'(start && !busy) - int'(done_o);
      if (start && !busy) verdict_q = {verdict_q, predict_verdict(candidate_i)};
      if (done_o) begin
        got = '{tested_value: tested_value_o, is_prime: is_prime_o,
                out_of_range: out_of_range_o};
        n_tested++;
        if (is_prime_o) n_prime++;
        if (out_of_range_o) n_oor++;
        if (verdict_q.size() == 0) begin
          $display("%0t: result beat with nothing pending: value %0d prime %0b oor %0b",
                   $time, got.tested_value, got.is_prime, got.out_of_range);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     $time, want.tested_value, want.is_prime, want.out_of_range,
                     got.tested_value, got.is_prime, got.out_of_range);
            mismatches++;
          end
        end
      end
      if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // sequencer: reset, then per phase a limit write (none in the first), edge candidates,
  // random ones, and a full drain so the limit only changes while the block is idle
  initial begin
    int p;
    phase_limit[5] = LIMIT_W'($urandom_range(3, 1 << 20));
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (p = 0; p < N_PHASES; p++) begin
      if (p != 0) begin
        @(negedge clk_i);
        cfg_valid_i = 1'b1;
        cfg_data_i  = phase_limit[p];
        do @(posedge clk_i); while (!cfg_ready_o);
        limit_model = phase_limit[p];
        @(negedge clk_i);
        cfg_valid_i = 1'b0;
      end
      foreach (EDGE_VALUES[k]) if (EDGE_PHASE[k] == p) cand_q = {cand_q, EDGE_VALUES[k]};
      repeat (RANDOM_PER_PHASE[p]) cand_q = {cand_q, draw_candidate()};
      // the sequencer waits here until every predicted verdict has come back
      do @(posedge clk_i); while (cand_q.size() != 0 || start || outstanding != 0);
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d expected verdicts never arrived", $time, verdict_q.size());
      mismatches++;
    end
    $display("checked %0d candidates (%0d prime, %0d over the limit) across %0d limit settings",
             n_tested, n_prime, n_oor, N_PHASES);
    $display("limits covered: 0, 1, 2, 1000000, %0d and 2^32-1", phase_limit[5]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
